FILE: hw/rtl/sobel_edge_magnitude_rgb_defines.svh
// ----------------------------------------------------------------------------
// Sobel edge magnitude: assertion macros
// These macros wrap concurrent assertions. They expand to nothing when SYNTHESIS
// is defined.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`ifndef SYNTHESIS
`define SEM_ASSERT_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("sem check");
`define SEM_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("sem check");
`else
`define SEM_ASSERT_IMPL(lbl, clk, rst, a, c)
`define SEM_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

FILE: hw/rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared constants, command and register codes and the pixel type.
// ----------------------------------------------------------------------------
package sem_pkg;
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;
  localparam int unsigned CfgW = 11;
  localparam logic [10:0] ResetWidth  = 11'd640;
  localparam logic [10:0] ResetHeight = 11'd480;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;
endpackage

FILE: hw/rtl/sem_if.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude channel interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, command, red, green, blue, input ready);
  modport sink (input valid, command, red, green, blue, output ready);
endinterface

interface sem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

interface sem_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/sem_mag.sv
// ----------------------------------------------------------------------------
// Sobel magnitude for one channel
// Gx, Gy from a 3x3 window; squared sum registered, then a rounded square
// root over eight registered bit steps.
// ----------------------------------------------------------------------------
module sem_mag
  import sem_pkg::*;
(
  input  logic       clk,
  input  logic       start,
  input  logic [7:0] p00, p01, p02, p10, p12, p20, p21, p22,
  output logic [7:0] root
);
  logic signed [10:0] gx, gy;
  logic signed [21:0] gxw, gyw, sqx, sqy;
  logic [21:0] sum;
  logic [21:0] s;
  logic [7:0]  n;
  logic [7:0]  bitm;
  logic [7:0]  t;
  logic [15:0] tsq;
  logic [15:0] nsq;
  logic [21:0] rem;

  always_comb begin
    gx = -$signed({3'b0, p00}) + $signed({3'b0, p02}) - $signed({2'b0, p10, 1'b0})
         + $signed({2'b0, p12, 1'b0}) - $signed({3'b0, p20}) + $signed({3'b0, p22});
    gy = -$signed({3'b0, p00}) - $signed({2'b0, p01, 1'b0}) - $signed({3'b0, p02})
         + $signed({3'b0, p20}) + $signed({2'b0, p21, 1'b0}) + $signed({3'b0, p22});
    gxw = {{11{gx[10]}}, gx};
    gyw = {{11{gy[10]}}, gy};
    sqx = gxw * gxw;
    sqy = gyw * gyw;
    sum = $unsigned(sqx) + $unsigned(sqy);
  end

  always_comb begin
    t   = n | bitm;
    tsq = t * t;
    nsq = n * n;
    rem = s - {6'd0, nsq};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s    <= sum;
      n    <= 8'd0;
      bitm <= 8'h80;
    end else if (bitm != 8'd0) begin
      if ({6'd0, tsq} <= s) n <= t;
      bitm <= bitm >> 1;
    end
  end

  always_comb begin
    if (s > 22'd65280) root = 8'd255;
    else if (rem > {14'd0, n}) root = n + 8'd1;
    else root = n;
  end
endmodule

FILE: hw/rtl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude over an RGB raster stream
//   channel   dir   payload
//   pix_in    in    command, red, green, blue
//   edge_out  out   edge_red, edge_green, edge_blue, frame_end
//   cfg       in    index, data
// A transaction that yields a result passes the line store read, window update,
// squared-sum register, eight square-root bit steps and output register. The
// next transaction is taken only after the result leaves. One that is scanned
// but yields nothing passes only the line store read and window update; a
// drain that needs a second window pass repeats both.
// Synchronous reset clears control; line stores stay unset until written.
// Output stall holds the result register; input is taken when it is free and no cfg write waits.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input logic clk,
  input logic rst,
  sem_in_if.sink   pix_in,
  sem_out_if.source edge_out,
  sem_cfg_if.sink  cfg
);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_ADV, S_ROOT, S_OUT} state_t;
  state_t state;

  logic [23:0] older_mem [MAX_WIDTH];
  logic [23:0] prior_mem [MAX_WIDTH];
  logic [23:0] older_rd, prior_rd;

  logic [10:0] frame_width, frame_height;
  logic [AW:0] col;
  logic [HW-1:0] row;
  logic [23:0] win [3][3];
  pix_t        pix;
  logic        drain, second, fe;
  logic [3:0]  cnt;
  logic        mstart;
  logic [23:0] m [3][3];
  logic [7:0]  roots [3];

  logic [13:0] wfull, hfull, w_eff, h_eff;
  always_comb begin
    wfull = {3'b0, frame_width};
    hfull = {3'b0, frame_height};
    if (frame_width == 11'd0) w_eff = 14'd1;
    else if (wfull > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    else w_eff = wfull;
    if (frame_height == 11'd0) h_eff = 14'd1;
    else if (hfull > 14'(MAX_HEIGHT)) h_eff = 14'(MAX_HEIGHT);
    else h_eff = hfull;
  end

  logic done;
  assign done = 14'(row) >= h_eff;
  assign pix_in.ready = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      older_rd <= older_mem[col[AW-1:0]];
      prior_rd <= prior_mem[col[AW-1:0]];
    end
    if (state == S_ADV && col < (AW+1)'(MAX_WIDTH) && !(col == '0 && row >= 2 &&
        14'(row) >= h_eff + 14'd1)) begin
      older_mem[col[AW-1:0]] <= prior_rd;
      prior_mem[col[AW-1:0]] <= pix;
    end
  end

  genvar k;
  generate
    for (k = 0; k < 3; k++) begin : g_ch
      sem_mag u_mag (
        .clk(clk), .start(mstart),
        .p00(m[0][0][23-8*k -: 8]), .p01(m[0][1][23-8*k -: 8]),
        .p02(m[0][2][23-8*k -: 8]), .p10(m[1][0][23-8*k -: 8]),
        .p12(m[1][2][23-8*k -: 8]), .p20(m[2][0][23-8*k -: 8]),
        .p21(m[2][1][23-8*k -: 8]), .p22(m[2][2][23-8*k -: 8]),
        .root(roots[k])
      );
    end
  endgenerate

  logic cfg_fire, in_fire, out_fire;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign in_fire  = pix_in.valid && pix_in.ready;
  assign out_fire = edge_out.valid && edge_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      frame_width <= ResetWidth;
      frame_height <= ResetHeight;
      col <= '0;
      row <= '0;
      win <= '{default: '0};
      edge_out.valid <= 1'b0;
      mstart <= 1'b0;
    end else begin
      mstart <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            if (cfg.index == REG_WIDTH) frame_width <= cfg.data;
            else frame_height <= cfg.data;
            col <= '0;
            row <= '0;
            win <= '{default: '0};
          end else if (in_fire) begin
            pix <= (pix_in.command == CMD_DRAIN) ? 24'd0
                   : {pix_in.red, pix_in.green, pix_in.blue};
            drain <= pix_in.command;
            second <= 1'b0;
            if ((pix_in.command == CMD_PIXEL) != done) state <= S_READ;
          end
        end
        S_READ: state <= S_ADV;
        S_ADV: begin
          fe <= 1'b0;
          state <= S_IDLE;
          if (col == '0 && row >= 2) begin
            m[0] <= '{win[0][1], win[0][2], 24'd0};
            m[1] <= '{win[1][1], win[1][2], 24'd0};
            m[2] <= '{win[2][1], win[2][2], 24'd0};
            mstart <= 1'b1;
            cnt <= 4'd0;
            state <= S_ROOT;
            if (14'(row) >= h_eff + 14'd1) begin
              fe <= 1'b1;
              col <= '0;
              row <= '0;
              win <= '{default: '0};
            end
          end
          if (!(col == '0 && row >= 2 && 14'(row) >= h_eff + 14'd1)) begin
            logic [23:0] top, mid;
            top = (row >= 2 && col < (AW+1)'(MAX_WIDTH)) ? older_rd : 24'd0;
            mid = (row >= 1 && col < (AW+1)'(MAX_WIDTH)) ? prior_rd : 24'd0;
            if (col == '0) begin
              win <= '{'{24'd0, 24'd0, top}, '{24'd0, 24'd0, mid}, '{24'd0, 24'd0, pix}};
            end else begin
              win <= '{'{win[0][1], win[0][2], top}, '{win[1][1], win[1][2], mid},
                       '{win[2][1], win[2][2], pix}};
            end
            if (col >= 1 && row >= 1) begin
              m <= '{'{win[0][1], win[0][2], top}, '{win[1][1], win[1][2], mid},
                     '{win[2][1], win[2][2], pix}};
              mstart <= 1'b1;
              cnt <= 4'd0;
              state <= S_ROOT;
            end
            if (14'(col) + 14'd1 >= w_eff) begin
              col <= '0;
              row <= row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
            if (!(col >= 1 && row >= 1) && !(col == '0 && row >= 2) && drain && !second) begin
              second <= 1'b1;
              state <= S_READ;
            end
          end
        end
        S_ROOT: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd9) begin
            edge_out.edge_red <= roots[0];
            edge_out.edge_green <= roots[1];
            edge_out.edge_blue <= roots[2];
            edge_out.frame_end <= fe;
            edge_out.valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            edge_out.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "sobel_edge_magnitude_rgb_defines.svh"
  `SEM_ASSERT_IMPL(a_out_state, clk, rst, edge_out.valid, state == S_OUT)
  `SEM_ASSERT_IMPL(a_no_in_busy, clk, rst, state != S_IDLE, !pix_in.ready)
  `SEM_ASSERT_NEXT(a_start_root, clk, rst, mstart, state == S_ROOT)
endmodule

FILE: tb/sem_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench: shared package
// The channel interfaces are taken from the RTL file sem_if.sv, which is compiled
// with the design, so this file only holds the bench package with the timeout limit.
// ----------------------------------------------------------------------------
package sem_tb_pkg;
  localparam int unsigned TimeoutCycles = 2000000;
endpackage

FILE: tb/sobel_edge_magnitude_rgb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams frames of RGB pixels and drain transactions through the block under
// several frame sizes, predicts each edge result with an in-bench Sobel scan
// and compares the results in order. Sender bursts and receiver stalls vary.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_tb;
  import sem_pkg::*;
  import sem_tb_pkg::*;

  typedef struct packed {
    logic [7:0] er;
    logic [7:0] eg;
    logic [7:0] eb;
    logic       fe;
  } edge_t;

  typedef struct {
    logic       cmd;
    logic [23:0] pix;
    logic       chk;
    edge_t      res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sem_in_if  pix_in ();
  sem_out_if edge_out ();
  sem_cfg_if cfg ();

  sobel_edge_magnitude_rgb uut (
    .clk(clk), .rst(rst), .pix_in(pix_in), .edge_out(edge_out), .cfg(cfg)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  int unsigned fw, fh;
  logic [23:0] line_old [DefMaxWidth];
  logic [23:0] line_prev [DefMaxWidth];
  logic [23:0] win [3][3];
  int unsigned col, row;
  edge_t expected_edges[$];
  edge_t typed_edges[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic hold_off = 1'b0;
  logic hold_go = 1'b0;

  function automatic int unsigned width_used();
    if (fw == 0) return 1;
    if (fw > DefMaxWidth) return DefMaxWidth;
    return fw;
  endfunction

  function automatic int unsigned height_used();
    if (fh == 0) return 1;
    if (fh > DefMaxHeight) return DefMaxHeight;
    return fh;
  endfunction

  function automatic logic [7:0] rounded_root(int unsigned s);
    int unsigned n, t;
    n = 0;
    if (s > 65280) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = n | (1 << b);
      if (t * t <= s) n = t;
    end
    if (s - n * n > n) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  function automatic int chan_at(int r, int c, int sh);
    if (c > 2) return 0;
    return int'((win[r][c] >> sh) & 24'hff);
  endfunction

  function automatic edge_t sobel_mag(int l, int m, int rt);
    edge_t e;
    int gx, gy, sh;
    logic [7:0] v [3];
    for (int k = 0; k < 3; k++) begin
      sh = 16 - 8 * k;
      gx = -chan_at(0, l, sh) + chan_at(0, rt, sh) - 2 * chan_at(1, l, sh)
           + 2 * chan_at(1, rt, sh) - chan_at(2, l, sh) + chan_at(2, rt, sh);
      gy = -chan_at(0, l, sh) - 2 * chan_at(0, m, sh) - chan_at(0, rt, sh)
           + chan_at(2, l, sh) + 2 * chan_at(2, m, sh) + chan_at(2, rt, sh);
      v[k] = rounded_root(gx * gx + gy * gy);
    end
    e.er = v[0];
    e.eg = v[1];
    e.eb = v[2];
    e.fe = 1'b0;
    return e;
  endfunction

  function automatic void frame_restart();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    col = 0;
    row = 0;
  endfunction

  function automatic bit scan_step(logic [23:0] pix, output edge_t e);
    int unsigned w, r, c;
    logic [23:0] top, mid;
    bit made;
    w = width_used();
    r = row;
    c = col;
    top = '0;
    mid = '0;
    made = 1'b0;
    if (c == 0) begin
      if (r >= 2) begin
        e = sobel_mag(1, 2, 3);
        made = 1'b1;
        if (r >= height_used() + 1) begin
          e.fe = 1'b1;
          frame_restart();
          return 1'b1;
        end
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    if (r >= 2) top = line_old[c];
    if (r >= 1) mid = line_prev[c];
    line_old[c] = line_prev[c];
    line_prev[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;
    if (c >= 1 && r >= 1) begin
      e = sobel_mag(0, 1, 2);
      made = 1'b1;
    end
    if (c + 1 >= w) begin
      col = 0;
      row = r + 1;
    end else begin
      col = c + 1;
    end
    return made;
  endfunction

  function automatic bit predict_edge(logic cmd, logic [23:0] pix, output edge_t e);
    bit done;
    done = row >= height_used();
    if (cmd == CMD_PIXEL) begin
      if (done) return 1'b0;
      return scan_step(pix, e);
    end
    if (!done) return 1'b0;
    if (scan_step('0, e)) return 1'b1;
    return scan_step('0, e);
  endfunction

  // pixel channel driver
  task automatic send_item(logic cmd, logic [23:0] pix);
    pix_in.valid   <= 1'b1;
    pix_in.command <= cmd;
    {pix_in.red, pix_in.green, pix_in.blue} <= pix;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  task automatic go_idle();
    pix_in.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [10:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_WIDTH) fw = 32'(val);
    else fh = 32'(val);
    frame_restart();
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // predictor runs on accepted transactions
  always @(posedge clk) begin
    edge_t e;
    if (!rst && pix_in.valid && pix_in.ready) begin
      if (predict_edge(pix_in.command, {pix_in.red, pix_in.green, pix_in.blue}, e)) begin
        expected_edges.push_back(e);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    edge_t got, want;
    if (!rst && edge_out.valid && edge_out.ready) begin
      got = {edge_out.edge_red, edge_out.edge_green, edge_out.edge_blue, edge_out.frame_end};
      if (expected_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_edges.pop_front();
        if (typed_edges.size() != 0) begin
          if (typed_edges[0] != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("table row: expected %h, predicted %h", typed_edges[0], want);
          end
          void'(typed_edges.pop_front());
        end
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h, actual %h", want, got);
        end
      end
    end
  end

  // receiver stall pattern plus long hold-off
  always @(posedge clk) begin
    if (rst) edge_out.ready <= 1'b0;
    else if (hold_off) edge_out.ready <= 1'b0;
    else if (cycles[9:6] == 4'd3) edge_out.ready <= 1'b1;
    else edge_out.ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TimeoutCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic random_gap();
    if ($urandom_range(0, 4) == 0) begin
      go_idle();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // one frame of random pixels then its drains
  task automatic run_frame(int unsigned w, int unsigned h, bit noisy);
    int unsigned n;
    n = w * h;
    for (int unsigned i = 0; i < n; i++) begin
      send_item(CMD_PIXEL, $urandom_range(0, 3) == 0 ? {3{8'hff}} : 24'($urandom));
      if (noisy && $urandom_range(0, 15) == 0) send_item(CMD_DRAIN, 24'($urandom));
      random_gap();
    end
    if (noisy) send_item(CMD_PIXEL, 24'($urandom));
    for (int unsigned i = 0; i <= w + 1; i++) begin
      send_item(CMD_DRAIN, 24'($urandom));
      random_gap();
    end
    go_idle();
  endtask

  row_t dir_rows [$];
  int unsigned sizes_w [6] = '{1, 2, 3, 5, 8, 17};
  int unsigned sizes_h [6] = '{1, 4, 2, 3, 6, 2};
  int unsigned items;

  initial begin
    row_t rr;
    pix_in.valid = 1'b0;
    pix_in.command = CMD_PIXEL;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_WIDTH;
    cfg.data = '0;
    fw = 32'(ResetWidth);
    fh = 32'(ResetHeight);
    frame_restart();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 2x2 frame of extremes, drain-before-end ignored
    write_reg(REG_WIDTH, 11'd2);
    write_reg(REG_HEIGHT, 11'd2);
    dir_rows.push_back('{CMD_DRAIN, 24'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_PIXEL, 24'h000000, 1'b0, '0});
    dir_rows.push_back('{CMD_PIXEL, 24'hffffff, 1'b0, '0});
    dir_rows.push_back('{CMD_PIXEL, 24'hff00ff, 1'b0, '0});
    dir_rows.push_back('{CMD_PIXEL, 24'h00ff00, 1'b0, '0});
    dir_rows.push_back('{CMD_PIXEL, 24'h123456, 1'b0, '0});
    dir_rows.push_back('{CMD_DRAIN, 24'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_DRAIN, 24'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_DRAIN, 24'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_DRAIN, 24'h0, 1'b0, '0});
    foreach (dir_rows[i]) begin
      rr = dir_rows[i];
      if (rr.chk) typed_edges.push_back(rr.res);
      send_item(rr.cmd, rr.pix);
    end
    go_idle();
    wait_drained();

    // 1x1 frame: a lone pixel gives zero edges with frame_end
    write_reg(REG_WIDTH, 11'd1);
    write_reg(REG_HEIGHT, 11'd1);
    typed_edges.push_back('{8'd0, 8'd0, 8'd0, 1'b1});
    send_item(CMD_PIXEL, 24'hffffff);
    send_item(CMD_DRAIN, 24'h0);
    send_item(CMD_DRAIN, 24'h0);
    go_idle();
    wait_drained();

    // out-of-range values clamp; a 0 width means 1
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'd3);
    run_frame(1, 3, 0);
    wait_drained();
    // width clamps to the maximum: results appear from the second pixel of the second row on
    write_reg(REG_WIDTH, 11'd2047);
    write_reg(REG_HEIGHT, 11'd2);
    for (int i = 0; i < 1030; i++) begin
      send_item(CMD_PIXEL, 24'($urandom));
      random_gap();
    end
    go_idle();
    wait_drained();
    write_reg(REG_WIDTH, 11'd3);
    write_reg(REG_HEIGHT, 11'd2047);
    run_frame(3, 4, 1);  // partial frame, abandoned by the next write
    wait_drained();

    // random frames
    items = 0;
    hold_go = 1'b1;
    while (items < 430) begin
      int k;
      k = $urandom_range(0, 5);
      write_reg(REG_WIDTH, 11'(sizes_w[k]));
      write_reg(REG_HEIGHT, 11'(sizes_h[k]));
      repeat ($urandom_range(1, 3)) begin
        run_frame(sizes_w[k], sizes_h[k], $urandom_range(0, 3) == 0);
        items += sizes_w[k] * sizes_h[k] + sizes_w[k] + 2;
      end
      wait_drained();
    end

    while (expected_edges.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_edges.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
